@@ hdl/gmps_pkg.sv @@
// Shared types and constants for the grid minimum path sum block.
package gmps_pkg;

	localparam int CFG_W = 11;
	localparam int SUM_W = 32;

	typedef enum logic [0:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic first_row;
		logic first_col;
	} step_ctl_t;

	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

endpackage

@@ hdl/gmps_step.sv @@
// Per-cell update: pick the cheaper neighbour (the only one on an edge), add the cost, clamp the sum.
module gmps_step #(
	parameter int COST_WIDTH = 16
) (
	input  gmps_pkg::step_ctl_t          ctl,
	input  logic [gmps_pkg::SUM_W-1:0]   above,
	input  logic [gmps_pkg::SUM_W-1:0]   left,
	input  logic [COST_WIDTH-1:0]        cost,
	output logic [gmps_pkg::SUM_W-1:0]   sum,
	output logic                         sat
);
	import gmps_pkg::*;

	logic [SUM_W-1:0] prev;
	logic [SUM_W:0]   full;

	always_comb begin
		unique case ({ctl.first_row, ctl.first_col})
			2'b11: prev = '0;
			2'b10: prev = left;
			2'b01: prev = above;
			default: prev = (above < left) ? above : left;
		endcase
	end

	assign full = {1'b0, prev} + (SUM_W + 1)'(cost);
	assign sat  = full[SUM_W];
	assign sum  = sat ? SUM_LIMIT : full[SUM_W-1:0];

endmodule

@@ hdl/grid_min_path_sum.sv @@
// Top level of the grid minimum path sum block: row buffer, counters and result register.
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+----------------------------
//  input   | in_valid, in_stall, cell_cost    | in        | in_valid && !in_stall
//  output  | out_valid, out_stall, path_sum,  | out       | out_valid && !out_stall
//          | saturated                        |           |
//  config  | cfg_we, cfg_index, cfg_data      | in        | cfg_we
//
// One cell per cycle unless in_stall: a cell reads its row-buffer entry in the cycle it is
// taken and is summed and written back from stage one; a one-column grid forwards the sum.
// A result enters the output register as the bottom-right cell leaves stage one.
// Reset clears counters, left sum, flag and valids; the row buffer is not cleared.
// in_stall rises only when a bottom-right cell meets a full, stalled output register.
module grid_min_path_sum #(
	parameter int MAX_COLS   = 1024,
	parameter int MAX_ROWS   = 1024,
	parameter int COST_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COST_WIDTH-1:0]        cell_cost,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gmps_pkg::SUM_W-1:0]   path_sum,
	output logic                         saturated,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [gmps_pkg::CFG_W-1:0]   cfg_data
);
	import gmps_pkg::*;

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CLW = (CNW > CFG_W) ? CNW : CFG_W;
	localparam int RLW = (RNW > CFG_W) ? RNW : CFG_W;

	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CLW-1:0]   cols_ext, cols_eff;
	logic [RLW-1:0]   rows_ext, rows_eff;
	logic             last_col, last_row, in_fire;

	logic             valid_s1, first_row_s1, first_col_s1, last_s1, fwd_s1;
	logic [COST_WIDTH-1:0] cost_s1;
	logic [CW-1:0]    addr_s1;
	logic [SUM_W-1:0] rd_data_s1, fwd_data_s1;
	logic             fire_s1;

	logic [SUM_W-1:0] left_q;
	logic             sat_seen_q;
	logic [SUM_W-1:0] step_sum;
	logic             step_sat;
	step_ctl_t        ctl;

	logic [SUM_W-1:0] row_mem [MAX_COLS];

	assign cols_ext = CLW'(grid_cols_q);
	assign rows_ext = RLW'(grid_rows_q);

	always_comb begin
		priority if (cols_ext == '0) cols_eff = CLW'(1);
		else if (cols_ext > CLW'(MAX_COLS)) cols_eff = CLW'(MAX_COLS);
		else cols_eff = cols_ext;
		priority if (rows_ext == '0) rows_eff = RLW'(1);
		else if (rows_ext > RLW'(MAX_ROWS)) rows_eff = RLW'(MAX_ROWS);
		else rows_eff = rows_ext;
	end

	assign last_col = (CLW'(col_q) + CLW'(1)) >= cols_eff;
	assign last_row = (RLW'(row_q) + RLW'(1)) >= rows_eff;

	assign fire_s1  = valid_s1 && !(last_s1 && out_valid && out_stall);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(1);
			grid_cols_q <= CFG_W'(1);
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_row_s1 <= (row_q == '0);
			first_col_s1 <= (col_q == '0);
			last_s1      <= last_col && last_row;
			cost_s1      <= cell_cost;
			addr_s1      <= col_q;
			fwd_s1       <= fire_s1 && (addr_s1 == col_q);
			fwd_data_s1  <= step_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_data_s1 <= row_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			row_mem[addr_s1] <= step_sum;
		end
	end

	assign ctl.first_row = first_row_s1;
	assign ctl.first_col = first_col_s1;

	gmps_step #(
		.COST_WIDTH(COST_WIDTH)
	) u_step (
		.ctl  (ctl),
		.above(fwd_s1 ? fwd_data_s1 : rd_data_s1),
		.left (left_q),
		.cost (cost_s1),
		.sum  (step_sum),
		.sat  (step_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			sat_seen_q <= 1'b0;
		end else if (cfg_we) begin
			left_q     <= '0;
			sat_seen_q <= 1'b0;
		end else if (fire_s1) begin
			left_q     <= last_s1 ? '0 : step_sum;
			sat_seen_q <= last_s1 ? 1'b0 : (sat_seen_q | step_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			path_sum  <= step_sum;
			saturated <= sat_seen_q | step_sat;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire_s1 && last_s1 && out_valid && out_stall))
		else $error("result register overwritten while held");

	a_stall_holds_cell: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stalled cell lost from stage one");

	a_fwd_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s1) && fwd_s1 |-> $past(fire_s1))
		else $error("forward without a write in the previous cycle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire_s1 && last_s1))
		else $error("result without a bottom-right cell");

endmodule
